[rtl/core/pkmap_pkg.sv]
// pkmap_pkg: shared types, codes and the crc-32c byte step for the pair-key map
// depends on nothing; imported by pkmap_front, pkmap_back and the top

package pkmap_pkg;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam int          KEY_W    = 32;
  localparam int          ENTRY_W  = 3 * KEY_W;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CRC,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EVAL
  } back_state_t;

  // reflected crc-32c over one byte, lsb first
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/pkmap_front.sv]
// pkmap_front: accepts an item, hashes the key with crc-32c one byte a cycle,
// reduces the hash to a bucket index by reciprocal multiply and correction; depends on pkmap_pkg

module pkmap_front import pkmap_pkg::*; #(
  parameter int BUCKETS = 256,
  parameter int BW      = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               run,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_key_name,
  input  logic [31:0]        in_key_parent_type,
  input  logic [31:0]        in_new_value,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [BW-1:0]      push_bucket,
  output logic [31:0]        push_name,
  output logic [31:0]        push_pt,
  output logic [31:0]        push_value
);

  // quotient estimate floor(h * RECIP / 2^SH) is low by at most one
  localparam int          LG      = $clog2(BUCKETS);
  localparam int          SH      = 31 + LG;
  localparam logic [63:0] RECIP_L = (64'd1 << SH) / 64'(BUCKETS);
  localparam logic [31:0] RECIP   = RECIP_L[31:0];
  localparam logic [31:0] BUCK_C  = 32'(BUCKETS);

  front_state_t state_r, state_nxt;
  logic [2:0]    step_r;
  logic [31:0]   name_r, pt_r, val_r;
  logic [31:0]   crc_r, hash_r;
  logic [63:0]   prod_r;
  logic [31:0]   qd_r;
  logic [BW-1:0] rem_r;
  logic [63:0]   key_w;
  logic [7:0]    byte_w;
  logic [31:0]   crc_step;
  logic [31:0]   quot_w;
  logic [31:0]   diff_w;
  logic [BW-1:0] rem_step;
  logic          accept;

  assign key_w    = {pt_r, name_r};
  assign byte_w   = key_w[{step_r, 3'b000} +: 8];
  assign crc_step = crc32c_byte(crc_r, byte_w);
  assign accept   = in_valid && in_ready;

  assign quot_w   = 32'(prod_r >> SH);
  assign diff_w   = hash_r - qd_r;
  assign rem_step = (diff_w >= BUCK_C) ? BW'(diff_w - BUCK_C) : BW'(diff_w);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid && run) state_nxt = F_CRC;
      F_CRC:  if (step_r == 3'd7) state_nxt = F_MOD;
      F_MOD:  if (step_r == 3'd2) state_nxt = F_PUSH;
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    case (state_r)
      F_IDLE:  in_ready = run;
      F_PUSH:  push_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        step_r <= '0;
      end else if (state_r == F_CRC || state_r == F_MOD) begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      name_r <= in_key_name;
      pt_r   <= in_key_parent_type;
      val_r  <= in_new_value;
      crc_r  <= CRC_INIT;
    end
    if (state_r == F_CRC) begin
      crc_r <= crc_step;
      if (step_r == 3'd7) begin
        hash_r <= ~crc_step;
      end
    end
    if (state_r == F_MOD) begin
      if (step_r == 3'd0) begin
        prod_r <= {32'd0, hash_r} * {32'd0, RECIP};
      end else if (step_r == 3'd1) begin
        qd_r <= quot_w * BUCK_C;
      end else if (step_r == 3'd2) begin
        rem_r <= rem_step;
      end
    end
  end

  assign push_bucket = rem_r;
  assign push_name   = name_r;
  assign push_pt     = pt_r;
  assign push_value  = val_r;

endmodule

[rtl/core/pkmap_queue.sv]
// pkmap_queue: two-entry fifo between front and back
// depends on nothing

module pkmap_queue #(
  parameter int W = 104
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;
  logic         do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= ~wr_ptr_r;
      if (do_rd) rd_ptr_r <= ~rd_ptr_r;
      if (do_wr && !do_rd) begin
        count_r <= count_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wr_ptr_r] <= wr_data;
  end

endmodule

[rtl/core/pkmap_back.sv]
// pkmap_back: bucket memory (fill count plus all ways per row), lookup with a
// parallel compare, insert by row write-back, result register; depends on pkmap_pkg

module pkmap_back import pkmap_pkg::*; #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 8,
  parameter int BW      = 8,
  parameter int FW      = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          run,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  logic [BW-1:0] pop_bucket,
  input  logic [31:0]   pop_name,
  input  logic [31:0]   pop_pt,
  input  logic [31:0]   pop_value,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [31:0]   out_found_value
);

  localparam int RW = FW + WAYS * ENTRY_W;

  logic [RW-1:0] mem [BUCKETS];

  back_state_t   state_r, state_nxt;
  logic [BW-1:0] clr_cnt_r;
  logic [BW-1:0] bucket_r;
  logic [31:0]   k_name_r, k_pt_r, k_val_r;
  logic [RW-1:0] rd_data_r;
  logic          out_valid_r;
  status_t       out_status_r;
  logic [31:0]   out_value_r;

  logic          clearing, rd_en, fire, wr_en;
  logic [BW-1:0] wr_addr;
  logic [RW-1:0] wr_data, new_row;
  logic [FW-1:0] fill_w;
  logic          hit_w, full_w;
  logic [31:0]   hit_val;
  status_t       status_w;

  assign fill_w = rd_data_r[RW-1 -: FW];
  assign full_w = (fill_w == FW'(WAYS));

  // first matching way wins
  always_comb begin
    hit_w   = 1'b0;
    hit_val = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (FW'(w) < fill_w &&
          rd_data_r[w*ENTRY_W +: 32] == k_name_r &&
          rd_data_r[w*ENTRY_W + 32 +: 32] == k_pt_r) begin
        hit_w   = 1'b1;
        hit_val = rd_data_r[w*ENTRY_W + 64 +: 32];
      end
    end
  end

  always_comb begin
    new_row = rd_data_r;
    for (int w = 0; w < WAYS; w++) begin
      if (FW'(w) == fill_w) begin
        new_row[w*ENTRY_W +: ENTRY_W] = {k_val_r, k_pt_r, k_name_r};
      end
    end
    new_row[RW-1 -: FW] = fill_w + FW'(1);
  end

  always_comb begin
    if (hit_w) begin
      status_w = ST_FOUND;
    end else if (full_w) begin
      status_w = ST_FULL;
    end else begin
      status_w = ST_INSERTED;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR: if (clr_cnt_r == BW'(BUCKETS - 1)) state_nxt = B_IDLE;
      B_IDLE:  if (pop_valid) state_nxt = B_EVAL;
      B_EVAL:  if (!out_valid_r || out_ready) state_nxt = B_IDLE;
      default: state_nxt = B_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = 1'b0;
    pop_ready = 1'b0;
    fire      = 1'b0;
    case (state_r)
      B_CLEAR: clearing = 1'b1;
      B_IDLE:  pop_ready = 1'b1;
      B_EVAL:  fire = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign run     = !clearing;
  assign rd_en   = pop_valid && pop_ready;
  assign wr_en   = clearing || (fire && !hit_w && !full_w);
  assign wr_addr = clearing ? clr_cnt_r : bucket_r;
  assign wr_data = clearing ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[pop_bucket];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + BW'(1);
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      bucket_r <= pop_bucket;
      k_name_r <= pop_name;
      k_pt_r   <= pop_pt;
      k_val_r  <= pop_value;
    end
    if (fire) begin
      out_status_r <= status_w;
      out_value_r  <= hit_w ? hit_val : 32'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;

endmodule

[rtl/core/pair_key_get_or_insert_map_top.sv]
// pair_key_get_or_insert_map_top: get-or-insert map keyed by a pair of words
// depends on pkmap_pkg, pkmap_front, pkmap_queue, pkmap_back
//
//   channel | ports                                             | handshake
//   in      | in_key_name, in_key_parent_type, in_new_value      | in_valid / in_ready
//   out     | out_status, out_found_value                        | out_valid / out_ready
//
// the front handles one item at a time: accept, 8 crc-32c byte steps, 3 steps of
// the bucket remainder unit (reciprocal multiply, multiply back, correct) and
// hand-off; the back reads the bucket row, then compares and writes back.
// after reset the bucket memory is cleared one row a cycle with in_ready low. the
// queue lets the front hash the next item while a result waits on out_ready.

module pair_key_get_or_insert_map_top import pkmap_pkg::*; #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_key_name,
  input  logic [31:0] in_key_parent_type,
  input  logic [31:0] in_new_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_value
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int FW = $clog2(WAYS + 1);
  localparam int QW = BW + 3 * KEY_W;

  logic          run;
  logic          push_valid, push_ready;
  logic [BW-1:0] push_bucket;
  logic [31:0]   push_name, push_pt, push_value;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] q_in, q_out;

  pkmap_front #(
    .BUCKETS(BUCKETS),
    .BW     (BW)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .run               (run),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_key_name       (in_key_name),
    .in_key_parent_type(in_key_parent_type),
    .in_new_value      (in_new_value),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_bucket       (push_bucket),
    .push_name         (push_name),
    .push_pt           (push_pt),
    .push_value        (push_value)
  );

  assign q_in = {push_bucket, push_name, push_pt, push_value};

  pkmap_queue #(
    .W(QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_data (q_in),
    .rd_valid(pop_valid),
    .rd_ready(pop_ready),
    .rd_data (q_out)
  );

  pkmap_back #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS),
    .BW     (BW),
    .FW     (FW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .run            (run),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_bucket     (q_out[QW-1 -: BW]),
    .pop_name       (q_out[95:64]),
    .pop_pt         (q_out[63:32]),
    .pop_value      (q_out[31:0]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found_value(out_found_value)
  );

endmodule
